// File: rtl/core/ncomix_pkg.sv
`default_nettype none

package ncomix_pkg;

   // Oscillator table configuration.
   localparam int NCO_AMPLITUDE = 128;
   localparam int TABLE_BITS    = 10;

   // Field widths.
   localparam int SAMPLE_W  = 16;
   localparam int PHASE_W   = 32;
   localparam int DIVISOR_W = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // Quarter-wave table geometry.
   localparam int QBITS     = TABLE_BITS - 2;
   localparam int LUT_DEPTH = 1 << QBITS;
   localparam int AMP_W     = $clog2(NCO_AMPLITUDE + 1);

   // The divider retires this many quotient bits per cycle.
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_STEPS          = SAMPLE_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_STEP_W         = $clog2(DIV_STEPS);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDE_BY = CSR_IDX_W'(1);

   // Two pi in Q30 radians.
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

   typedef logic [AMP_W-1:0] lut_type [LUT_DEPTH];

   // Quarter-wave sine sample, evaluated at elaboration by a Taylor series to x^17.
   function automatic logic [AMP_W-1:0] quarter_sin(int unsigned r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        scaled;
      x = ((64'(r) * TWO_PI_Q30) + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      scaled = (64'(sum) * 64'(NCO_AMPLITUDE)) >> 30;
      if (r == 0) begin
         scaled = '0;
      end
      return AMP_W'(scaled);
   endfunction

   function automatic lut_type build_lut();
      lut_type t;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         t[i] = quarter_sin(i);
      end
      return t;
   endfunction

   // Quarter-wave table: entry r holds the sine at r quarter steps.
   localparam lut_type SIN_LUT = build_lut();

endpackage

`default_nettype wire

// File: rtl/core/nco_complex_mixer_core.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall sample_re, sample_im, load_phase, start_phase
// rsp      out        rsp_valid/rsp_stall out_re, out_im, phase_after
// csr      in         csr_we              csr_index, csr_wdata (write only)
//
// Between acceptance and the next acceptance an item goes through one table lookup,
// four passes of the shared 16x16 multiplier and the shared divider, which retires two
// quotient bits per cycle for each of the two parts. The input side stalls while an item
// is in flight.
// Reset is synchronous and active high; it clears the phase accumulator and sets the
// divisor to one. A stalled result waits in the output register while the next item
// is already being worked on; that item then waits until the register is free.

module nco_complex_mixer_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [ncomix_pkg::SAMPLE_W-1:0] req_sample_re,
   input  wire logic signed [ncomix_pkg::SAMPLE_W-1:0] req_sample_im,
   input  wire logic                                  req_load_phase,
   input  wire logic [ncomix_pkg::PHASE_W-1:0]        req_start_phase,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [ncomix_pkg::SAMPLE_W-1:0]     rsp_out_re,
   output logic signed [ncomix_pkg::SAMPLE_W-1:0]     rsp_out_im,
   output logic [ncomix_pkg::PHASE_W-1:0]             rsp_phase_after,
   input  wire logic                                  csr_we,
   input  wire logic [ncomix_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ncomix_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ncomix_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // Multiplier passes.
   localparam logic [1:0] MUL_RE_COS = 2'd0;
   localparam logic [1:0] MUL_RE_SIN = 2'd1;
   localparam logic [1:0] MUL_IM_SIN = 2'd2;
   localparam logic [1:0] MUL_IM_COS = 2'd3;

   // Quadrants of the phase.
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(DIV_STEPS - 1);

   logic [2:0]                state_ff, state_in;
   logic [PHASE_W-1:0]        phase_acc_ff, phase_acc_in;
   logic [PHASE_W-1:0]        phase_inc_ff, phase_inc_in;
   logic [DIVISOR_W-1:0]      divide_by_ff, divide_by_in;
   logic [1:0]                mul_step_ff, mul_step_in;
   logic [DIV_STEP_W-1:0]     div_step_ff, div_step_in;
   logic                      div_part_ff, div_part_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic [PHASE_W-1:0]        phase_after_ff, phase_after_in;
   logic [SAMPLE_W-1:0]       xr_ff, xr_in;
   logic [SAMPLE_W-1:0]       xi_ff, xi_in;
   logic [SAMPLE_W-1:0]       cv_ff, cv_in;
   logic [SAMPLE_W-1:0]       sv_ff, sv_in;
   logic [SAMPLE_W-1:0]       acc_re_ff, acc_re_in;
   logic [SAMPLE_W-1:0]       acc_im_ff, acc_im_in;
   logic [SAMPLE_W-1:0]       div_rem_ff, div_rem_in;
   logic [SAMPLE_W-1:0]       div_quo_ff, div_quo_in;
   logic                      div_neg_ff, div_neg_in;
   logic [SAMPLE_W-1:0]       res_re_ff, res_re_in;
   logic [SAMPLE_W-1:0]       rsp_re_ff, rsp_re_in;
   logic [SAMPLE_W-1:0]       rsp_im_ff, rsp_im_in;
   logic [PHASE_W-1:0]        rsp_phase_ff, rsp_phase_in;

   logic                      req_accept;
   logic                      rsp_free;
   logic [PHASE_W-1:0]        phase_start;
   logic [TABLE_BITS-1:0]     table_idx;
   logic [1:0]                quadrant;
   logic [QBITS-1:0]          quarter_pos;
   logic [QBITS-1:0]          quarter_comp;
   logic [SAMPLE_W-1:0]       sin_mag;
   logic [SAMPLE_W-1:0]       cos_mag;
   logic [SAMPLE_W-1:0]       mul_a;
   logic [SAMPLE_W-1:0]       mul_b;
   logic [SAMPLE_W-1:0]       mul_prod;
   logic [SAMPLE_W-1:0]       divisor;
   logic [SAMPLE_W-1:0]       step_rem;
   logic [SAMPLE_W-1:0]       step_quo;
   logic [SAMPLE_W-1:0]       trial;
   logic [SAMPLE_W-1:0]       div_result;
   logic [SAMPLE_W-1:0]       im_mag;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Phase in use for the incoming item.
   assign phase_start = req_load_phase ? req_start_phase : phase_acc_ff;

   // Quarter-wave lookup: the cosine reads the table mirrored about the quarter turn.
   assign table_idx    = phase_ff[PHASE_W-1 -: TABLE_BITS];
   assign quadrant     = table_idx[TABLE_BITS-1 -: 2];
   assign quarter_pos  = table_idx[QBITS-1:0];
   assign quarter_comp = -quarter_pos;
   assign sin_mag      = SAMPLE_W'(SIN_LUT[quarter_pos]);
   assign cos_mag      = (quarter_pos == '0) ? SAMPLE_W'(NCO_AMPLITUDE)
                                             : SAMPLE_W'(SIN_LUT[quarter_comp]);

   // Operand selection for the shared multiplier; only the low half of the product is kept.
   always_comb begin
      case (mul_step_ff)
         MUL_RE_COS: begin
            mul_a = xr_ff;
            mul_b = cv_ff;
         end
         MUL_RE_SIN: begin
            mul_a = xi_ff;
            mul_b = sv_ff;
         end
         MUL_IM_SIN: begin
            mul_a = xr_ff;
            mul_b = sv_ff;
         end
         default: begin
            mul_a = xi_ff;
            mul_b = cv_ff;
         end
      endcase
   end

   assign mul_prod = SAMPLE_W'(mul_a * mul_b);

   // A zero divisor acts as one.
   assign divisor = (divide_by_ff == '0) ? SAMPLE_W'(1) : SAMPLE_W'(divide_by_ff);

   // Restoring divider: two quotient bits per cycle on magnitudes.
   always_comb begin
      step_rem = div_rem_ff;
      step_quo = div_quo_ff;
      trial    = '0;
      for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
         trial    = {step_rem[SAMPLE_W-2:0], step_quo[SAMPLE_W-1]};
         step_quo = {step_quo[SAMPLE_W-2:0], 1'b0};
         if (trial >= divisor) begin
            trial       = trial - divisor;
            step_quo[0] = 1'b1;
         end
         step_rem = trial;
      end
   end

   assign div_result = div_neg_ff ? -step_quo : step_quo;
   assign im_mag     = acc_im_ff[SAMPLE_W-1] ? -acc_im_ff : acc_im_ff;

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      phase_acc_in   = phase_acc_ff;
      phase_inc_in   = phase_inc_ff;
      divide_by_in   = divide_by_ff;
      mul_step_in    = mul_step_ff;
      div_step_in    = div_step_ff;
      div_part_in    = div_part_ff;
      rsp_valid_in   = rsp_valid_ff;
      phase_in       = phase_ff;
      phase_after_in = phase_after_ff;
      xr_in          = xr_ff;
      xi_in          = xi_ff;
      cv_in          = cv_ff;
      sv_in          = sv_ff;
      acc_re_in      = acc_re_ff;
      acc_im_in      = acc_im_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_neg_in     = div_neg_ff;
      res_re_in      = res_re_ff;
      rsp_re_in      = rsp_re_ff;
      rsp_im_in      = rsp_im_ff;
      rsp_phase_in   = rsp_phase_ff;

      // Configuration writes; unknown indexes are ignored.
      if (csr_we) begin
         if (csr_index == CSR_PHASE_INC) begin
            phase_inc_in = csr_wdata[PHASE_W-1:0];
         end else if (csr_index == CSR_DIVIDE_BY) begin
            divide_by_in = csr_wdata[DIVISOR_W-1:0];
         end
      end

      // The result register empties when the consumer takes the item.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               xr_in          = req_sample_re;
               xi_in          = req_sample_im;
               phase_in       = phase_start;
               phase_after_in = phase_start + phase_inc_ff;
               phase_acc_in   = phase_start + phase_inc_ff;
               state_in       = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            case (quadrant)
               QUAD_FIRST: begin
                  cv_in = cos_mag;
                  sv_in = sin_mag;
               end
               QUAD_SECOND: begin
                  cv_in = -sin_mag;
                  sv_in = cos_mag;
               end
               QUAD_THIRD: begin
                  cv_in = -cos_mag;
                  sv_in = -sin_mag;
               end
               default: begin
                  cv_in = sin_mag;
                  sv_in = -cos_mag;
               end
            endcase
            mul_step_in = MUL_RE_COS;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            case (mul_step_ff)
               MUL_RE_COS: acc_re_in = mul_prod;
               MUL_RE_SIN: acc_re_in = acc_re_ff - mul_prod;
               MUL_IM_SIN: acc_im_in = mul_prod;
               default:    acc_im_in = acc_im_ff + mul_prod;
            endcase
            mul_step_in = mul_step_ff + 2'd1;
            if (mul_step_ff == MUL_IM_COS) begin
               // Real part is final; start its division.
               div_rem_in  = '0;
               div_quo_in  = acc_re_ff[SAMPLE_W-1] ? -acc_re_ff : acc_re_ff;
               div_neg_in  = acc_re_ff[SAMPLE_W-1];
               div_step_in = '0;
               div_part_in = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in  = step_rem;
            div_quo_in  = step_quo;
            div_step_in = div_step_ff + DIV_STEP_W'(1);
            if (div_step_ff == DIV_LAST) begin
               if (!div_part_ff) begin
                  // Real quotient done; the imaginary part follows.
                  res_re_in   = div_result;
                  div_rem_in  = '0;
                  div_quo_in  = im_mag;
                  div_neg_in  = acc_im_ff[SAMPLE_W-1];
                  div_part_in = 1'b1;
               end else begin
                  div_quo_in = div_result;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_re_in    = res_re_ff;
               rsp_im_in    = div_quo_ff;
               rsp_phase_in = phase_after_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_acc_ff <= '0;
         phase_inc_ff <= '0;
         divide_by_ff <= DIVISOR_W'(1);
         mul_step_ff  <= '0;
         div_step_ff  <= '0;
         div_part_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_acc_ff <= phase_acc_in;
         phase_inc_ff <= phase_inc_in;
         divide_by_ff <= divide_by_in;
         mul_step_ff  <= mul_step_in;
         div_step_ff  <= div_step_in;
         div_part_ff  <= div_part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      phase_ff       <= phase_in;
      phase_after_ff <= phase_after_in;
      xr_ff          <= xr_in;
      xi_ff          <= xi_in;
      cv_ff          <= cv_in;
      sv_ff          <= sv_in;
      acc_re_ff      <= acc_re_in;
      acc_im_ff      <= acc_im_in;
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      div_neg_ff     <= div_neg_in;
      res_re_ff      <= res_re_in;
      rsp_re_ff      <= rsp_re_in;
      rsp_im_ff      <= rsp_im_in;
      rsp_phase_ff   <= rsp_phase_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_re      = rsp_re_ff;
   assign rsp_out_im      = rsp_im_ff;
   assign rsp_phase_after = rsp_phase_ff;

   // An accepted item always moves on to the table lookup.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted item did not start its lookup");

   // The oscillator phase moves only when an item is accepted.
   assert property (@(posedge clock) disable iff (reset)
      (!req_accept && !reset) |=> $stable(phase_acc_ff))
      else $error("phase accumulator changed without an item");

   // A new result appears only from the final state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result register loaded outside the final state");

   // The last multiplier pass hands the real part to the divider.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MUL) && (mul_step_ff == MUL_IM_COS))
         |=> ((state_ff == ST_DIV) && (div_step_ff == '0) && !div_part_ff))
      else $error("divider not started after the multiplier passes");

endmodule

`default_nettype wire

// File: bench/tb_nco_complex_mixer_core.sv
module tb_nco_complex_mixer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ncomix_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int QSTEPS       = 1 << QBITS;
   localparam logic [63:0] TURN_Q30 = 64'd6746518852;

   // Register indexes that the block does not decode.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   // Phase step for a 1500 Hz offset at 2.048 MHz.
   localparam logic [31:0] STEP_1500HZ = 32'd3145728;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic [PHASE_W-1:0]         phase_after;
   } mix_out_type;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_SOLID} stall_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_W-1:0]    req_sample_re = '0;
   logic signed [SAMPLE_W-1:0]    req_sample_im = '0;
   logic                          req_load_phase = 1'b0;
   logic [PHASE_W-1:0]            req_start_phase = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_out_re;
   logic signed [SAMPLE_W-1:0]    rsp_out_im;
   logic [PHASE_W-1:0]            rsp_phase_after;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   // Oscillator state as the block should hold it.
   logic [PHASE_W-1:0]            osc_phase = '0;
   logic [PHASE_W-1:0]            osc_step = '0;
   logic [DIVISOR_W-1:0]          osc_divisor = DIVISOR_W'(1);
   int                            sine_lut [0:QSTEPS];

   mix_out_type                   pending_mix [$];
   int                            mismatches = 0;
   int                            cycle_count = 0;
   int                            burst_left = 0;
   int                            stall_left = 0;
   stall_mode_type                stall_mode = STALL_NONE;

   nco_complex_mixer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .req_load_phase  (req_load_phase),
      .req_start_phase (req_start_phase),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .rsp_phase_after (rsp_phase_after),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sine over one quarter turn, r steps of 2^-TABLE_BITS turns, by a Taylor series.
   function automatic int quarter_wave(int r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      if (r == 0) begin
         return 0;
      end
      if (r >= QSTEPS) begin
         return NCO_AMPLITUDE;
      end
      x = (64'(r) * TURN_Q30 + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(64'd1 << 30)) begin
         sum = $signed(64'd1 << 30);
      end
      return int'(($unsigned(sum) * 64'(NCO_AMPLITUDE)) >> 30);
   endfunction

   // Rotates one sample by the oscillator, divides it and advances the phase.
   function automatic mix_out_type mix_sample(logic signed [SAMPLE_W-1:0] s_re,
                                              logic signed [SAMPLE_W-1:0] s_im,
                                              logic load, logic [PHASE_W-1:0] start);
      logic [PHASE_W-1:0]      phase_used;
      logic [TABLE_BITS-1:0]   idx;
      int                      r;
      int                      s;
      int                      c;
      int                      cv;
      int                      sv;
      int                      divisor;
      logic signed [SAMPLE_W-1:0] re_w;
      logic signed [SAMPLE_W-1:0] im_w;
      mix_out_type             res;
      phase_used = load ? start : osc_phase;
      idx = phase_used[PHASE_W-1 -: TABLE_BITS];
      r = int'(idx[QBITS-1:0]);
      s = sine_lut[r];
      c = sine_lut[QSTEPS - r];
      case (idx[TABLE_BITS-1 -: 2])
         2'd0: begin
            cv = c;
            sv = s;
         end
         2'd1: begin
            cv = -s;
            sv = c;
         end
         2'd2: begin
            cv = -c;
            sv = -s;
         end
         default: begin
            cv = s;
            sv = -c;
         end
      endcase
      // Products wrap to 16 bits before the division.
      re_w = SAMPLE_W'(int'(s_re) * cv - int'(s_im) * sv);
      im_w = SAMPLE_W'(int'(s_re) * sv + int'(s_im) * cv);
      divisor = (osc_divisor == '0) ? 1 : int'(osc_divisor);
      res.re = SAMPLE_W'(int'(re_w) / divisor);
      res.im = SAMPLE_W'(int'(im_w) / divisor);
      res.phase_after = phase_used + osc_step;
      osc_phase = res.phase_after;
      return res;
   endfunction

   // Sends one item, in bursts of random length with random gaps between them.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s_re,
                              input logic signed [SAMPLE_W-1:0] s_im,
                              input logic load, input logic [PHASE_W-1:0] start);
      int gap_len;
      gap_len = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
      @(negedge clock);
      if (gap_len > 0) begin
         req_valid <= 1'b0;
         repeat (gap_len) @(negedge clock);
      end
      req_sample_re   <= s_re;
      req_sample_im   <= s_im;
      req_load_phase  <= load;
      req_start_phase <= start;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_mix.push_back(mix_sample(s_re, s_im, load, start));
      burst_left--;
   endtask

   // Writes one register; the block is idle whenever this is called.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PHASE_INC: osc_step = data;
         CSR_DIVIDE_BY: osc_divisor = data[DIVISOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Stops sending and waits until every expected item has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Full-scale and small samples at and between the quadrant boundaries, using the reset settings first.
   task automatic test_directed_extremes();
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b0, 32'h0000_0000);
      send_sample(16'sh7FFF, 16'sh0000, 1'b1, 32'h0000_0000);
      send_sample(-16'sh8000, -16'sh8000, 1'b1, 32'h4000_0000);
      send_sample(-16'sh8000, 16'sh7FFF, 1'b1, 32'h8000_0000);
      send_sample(16'sh7FFF, -16'sh8000, 1'b1, 32'hC000_0000);
      send_sample(16'sh0000, 16'sh0000, 1'b1, 32'hFFFF_FFFF);
      send_sample(16'sh0001, -16'sh0001, 1'b1, 32'h2000_0000);
      wait_idle();
      write_reg(CSR_PHASE_INC, 32'h0123_4567);
      write_reg(CSR_DIVIDE_BY, 32'h0000_0005);
      send_sample(16'sh1234, -16'sh4321, 1'b0, 32'hFFFF_FFFF);
      send_sample(-16'sh0001, 16'sh0001, 1'b0, 32'h0000_0000);
      send_sample(16'sh5555, 16'shAAAA, 1'b0, 32'h5555_5555);
      wait_idle();
   endtask

   // A zero divisor passes the wrapped products through undivided.
   task automatic test_zero_divisor();
      write_reg(CSR_DIVIDE_BY, 32'hFFFF_8000);
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 32'h1000_0000);
      send_sample(-16'sh8000, 16'sh0100, 1'b0, 32'h0);
      send_sample(16'sh00FF, -16'sh00FF, 1'b0, 32'h0);
      send_sample(16'sh4000, 16'sh4000, 1'b1, 32'hE000_0000);
      wait_idle();
   endtask

   // Writes to undecoded indexes must leave both registers alone.
   task automatic test_unknown_register();
      write_reg(CSR_DIVIDE_BY, 32'h0000_0003);
      write_reg(CSR_PHASE_INC, 32'hFEDC_BA98);
      write_reg(CSR_SPARE_A, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_B, 32'h0000_0000);
      send_sample(16'sh3000, -16'sh2000, 1'b1, 32'h7654_3210);
      send_sample(-16'sh3000, 16'sh2000, 1'b0, 32'h0);
      send_sample(16'sh0777, 16'sh0777, 1'b0, 32'h0);
      wait_idle();
   endtask

   // The phase wraps past the top of the turn; a step of exactly a half turn is also tried.
   task automatic test_phase_wrap();
      write_reg(CSR_PHASE_INC, 32'h7FFF_FFFF);
      write_reg(CSR_DIVIDE_BY, 32'h0000_7FFF);
      send_sample(-16'sh8000, -16'sh8000, 1'b1, 32'hFFFF_FFF0);
      send_sample(-16'sh8000, 16'sh7FFF, 1'b0, 32'h0);
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b0, 32'h0);
      wait_idle();
      write_reg(CSR_PHASE_INC, 32'h8000_0000);
      send_sample(16'sh7FFF, -16'sh8000, 1'b1, 32'h0000_0010);
      wait_idle();
   endtask

   // Long runs of random samples over a range of step and divisor settings.
   task automatic test_random_mixing();
      logic [PHASE_W-1:0]   step;
      logic [DIVISOR_W-1:0] divisor;
      logic                 load;
      for (int p = 0; p < 12; p++) begin
         case (p)
            0: begin
               step = STEP_1500HZ;
               divisor = DIVISOR_W'(1);
            end
            1: begin
               step = -STEP_1500HZ;
               divisor = DIVISOR_W'(2);
            end
            2: begin
               step = 32'h7FFF_FFFF;
               divisor = DIVISOR_W'(32767);
            end
            3: begin
               step = 32'h8000_0000;
               divisor = DIVISOR_W'(1);
            end
            default: begin
               step = $urandom;
               case ($urandom_range(0, 3))
                  0: divisor = DIVISOR_W'($urandom_range(1, 8));
                  1: divisor = DIVISOR_W'($urandom_range(1, 32767));
                  2: divisor = '0;
                  default: divisor = DIVISOR_W'($urandom_range(2, 300));
               endcase
            end
         endcase
         write_reg(CSR_PHASE_INC, step);
         // Upper data bits are random; only the low 15 reach the divisor.
         write_reg(CSR_DIVIDE_BY, {17'($urandom), divisor});
         if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
         end
         for (int i = 0; i < 150; i++) begin
            load = ($urandom_range(0, 15) == 0);
            send_sample(16'($urandom), 16'($urandom), load, $urandom);
         end
         wait_idle();
      end
   endtask

   // Result side stalls in stretches of varying character.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 30)
                                                     : $urandom_range(10, 120);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
            STALL_RARE:  rsp_stall <= ($urandom_range(0, 7) == 0);
            default:     rsp_stall <= 1'b1;
         endcase
      end
   end

   // Each accepted result is compared with the oldest expected one.
   always @(posedge clock) begin
      mix_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_mix.size() == 0) begin
            mismatches++;
            $display("%0t ns: item with none expected: re %0d im %0d phase %h", $time,
                     rsp_out_re, rsp_out_im, rsp_phase_after);
         end else begin
            want = pending_mix.pop_front();
            if (rsp_out_re !== want.re) begin
               mismatches++;
               $display("%0t ns: out_re expected %0d, got %0d", $time,
                        want.re, rsp_out_re);
            end
            if (rsp_out_im !== want.im) begin
               mismatches++;
               $display("%0t ns: out_im expected %0d, got %0d", $time,
                        want.im, rsp_out_im);
            end
            if (rsp_phase_after !== want.phase_after) begin
               mismatches++;
               $display("%0t ns: phase_after expected %h, got %h", $time,
                        want.phase_after, rsp_phase_after);
            end
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_nco_complex_mixer_core: done, errors");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      for (int r = 0; r <= QSTEPS; r++) begin
         sine_lut[r] = quarter_wave(r);
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_zero_divisor();
      test_unknown_register();
      test_phase_wrap();
      test_random_mixing();
      wait_idle();
      if (mismatches == 0) begin
         $display("tb_nco_complex_mixer_core: done, clean");
      end else begin
         $display("tb_nco_complex_mixer_core: done, errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/ncomix_pkg.sv
rtl/core/nco_complex_mixer_core.sv
bench/tb_nco_complex_mixer_core.sv
